FILE: src/arith_interval_decoder_defines.svh
// Assertion helpers used by the checker file
`ifndef ARITH_INTERVAL_DECODER_DEFINES_SVH
`define ARITH_INTERVAL_DECODER_DEFINES_SVH

// same-cycle implication
`define AID_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AID_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/aid_pkg.sv
package aid_pkg;

  localparam int unsigned DefMaxSymbols = 8;
  localparam int unsigned DefMaxCount   = 32;

  localparam int unsigned CodeW  = 32;
  localparam int unsigned CountW = 6;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned CharW  = 8;
  localparam int unsigned ProbW  = 16;
  localparam int unsigned SizeW  = 4;
  localparam int unsigned WidthW = 33;
  localparam int unsigned CfgW   = 64;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] RegAlphabetSize = 2'd0;
  localparam logic [CfgIdxW-1:0] RegProbsFirst   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegProbsLast    = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSymbolChars  = 2'd3;

  localparam logic [SizeW-1:0] AlphabetSizeRst = 4'd2;

  typedef struct packed {
    logic [CodeW-1:0]  code_value;
    logic [CountW-1:0] symbol_count;
  } aid_in_t;

  typedef struct packed {
    logic [IdxW-1:0]  symbol_index;
    logic [CharW-1:0] symbol_char;
    logic             last;
    logic             no_match;
  } aid_out_t;

  // sequencer -> datapath
  typedef struct packed {
    logic            load;    // new item: interval [0,1)
    logic            mul_en;  // register sub-width of trial symbol
    logic            step;    // move sub_low past the missed subinterval
    logic            take;    // narrow interval to the hit subinterval
    logic [IdxW-1:0] trial;
  } aid_ctrl_t;

  // datapath -> sequencer
  typedef struct packed {
    logic hit;
  } aid_stat_t;

endpackage

FILE: src/arith_interval_decoder.sv
// Each symbol is found by trying subintervals in order from index 0 up to the one hit,
// with two states per tried subinterval (multiply, compare) on the one shared 33x16 multiplier.
// The next start transfer is taken in the cycle the last result shows, so a new item is
// taken only once the current one is through; the receiver cannot stall.
// Reset (async, active low) returns to idle and restores register defaults.
module arith_interval_decoder
  import aid_pkg::*;
#(
  parameter int unsigned MAX_SYMBOLS = DefMaxSymbols,
  parameter int unsigned MAX_COUNT   = DefMaxCount
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  aid_in_t            in_i,
  output logic               valid_o,
  output aid_out_t           out_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  logic [SizeW-1:0] size_q;
  logic [CfgW-1:0]  probs_lo_q, probs_hi_q, chars_q;
  aid_ctrl_t        ctrl;
  aid_stat_t        stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q     <= AlphabetSizeRst;
      probs_lo_q <= '0;
      probs_hi_q <= '0;
      chars_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegAlphabetSize: size_q     <= cfg_data_i[SizeW-1:0];
        RegProbsFirst:   probs_lo_q <= cfg_data_i;
        RegProbsLast:    probs_hi_q <= cfg_data_i;
        RegSymbolChars:  chars_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  aid_seq #(
    .MAX_SYMBOLS(MAX_SYMBOLS),
    .MAX_COUNT  (MAX_COUNT)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .count_i(in_i.symbol_count),
    .size_i (size_q),
    .chars_i(chars_q),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy_o (busy),
    .valid_o(valid_o),
    .out_o  (out_o)
  );

  aid_datapath u_dp (
    .clk_i  (clk_i),
    .code_i (in_i.code_value),
    .probs_i({probs_hi_q, probs_lo_q}),
    .ctrl_i (ctrl),
    .stat_o (stat)
  );

endmodule

FILE: src/aid_datapath.sv
module aid_datapath
  import aid_pkg::*;
(
  input  logic              clk_i,
  input  logic [CodeW-1:0]  code_i,
  input  logic [2*CfgW-1:0] probs_i,
  input  aid_ctrl_t         ctrl_i,
  output aid_stat_t         stat_o
);

  logic [CodeW-1:0]        x_q;
  logic [WidthW-1:0]       width_q, sub_low_q, w_q;
  logic [ProbW-1:0]        prob;
  logic [WidthW+ProbW-1:0] prod;
  logic [WidthW:0]         hi;
  logic [WidthW-1:0]       hi_sat;

  assign prob = probs_i[ctrl_i.trial*ProbW +: ProbW];
  // the one shared multiplier
  assign prod = {{ProbW{1'b0}}, width_q} * {{WidthW{1'b0}}, prob};

  assign hi     = {1'b0, sub_low_q} + {1'b0, w_q};
  assign hi_sat = hi[WidthW] ? {WidthW{1'b1}} : hi[WidthW-1:0];

  assign stat_o.hit = ({1'b0, x_q} >= sub_low_q) && ({2'b00, x_q} < hi);

  // sub_low_q restarts at the interval low after each hit
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      x_q       <= code_i;
      width_q   <= {1'b1, {CodeW{1'b0}}};
      sub_low_q <= '0;
    end else if (ctrl_i.take) begin
      width_q   <= w_q;
      sub_low_q <= {1'b0, sub_low_q[CodeW-1:0]};
    end else if (ctrl_i.step) begin
      sub_low_q <= hi_sat;
    end
    if (ctrl_i.mul_en) begin
      w_q <= prod[WidthW+ProbW-1:ProbW];
    end
  end

endmodule

FILE: src/aid_seq.sv
module aid_seq
  import aid_pkg::*;
#(
  parameter int unsigned MAX_SYMBOLS = DefMaxSymbols,
  parameter int unsigned MAX_COUNT   = DefMaxCount
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [CountW-1:0] count_i,
  input  logic [SizeW-1:0]  size_i,
  input  logic [CfgW-1:0]   chars_i,
  input  aid_stat_t         stat_i,
  output aid_ctrl_t         ctrl_o,
  output logic              busy_o,
  output logic              valid_o,
  output aid_out_t          out_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMul  = 2'd1;
  localparam logic [1:0] StCmp  = 2'd2;

  localparam logic [CountW:0] MaxCnt = (CountW+1)'(MAX_COUNT);
  localparam logic [SizeW-1:0] MaxSym = SizeW'(MAX_SYMBOLS);

  logic [1:0]        state_q, state_d;
  logic [IdxW-1:0]   trial_q, trial_d;
  logic [CountW-1:0] left_q, left_d, left_dec;
  logic              valid_q, valid_d;
  aid_out_t          out_q, out_d;
  logic [CountW-1:0] cnt_sat;
  logic [SizeW-1:0]  nsym;
  logic              last_trial;

  assign cnt_sat = ({1'b0, count_i} > MaxCnt) ? MaxCnt[CountW-1:0] : count_i;
  assign nsym    = (size_i > MaxSym) ? MaxSym : size_i;
  assign last_trial = ({1'b0, trial_q} + 4'd1) == nsym;
  assign left_dec = left_q - 6'd1;

  always_comb begin
    state_d = state_q;
    trial_d = trial_q;
    left_d  = left_q;
    valid_d = 1'b0;
    out_d   = out_q;
    ctrl_o  = '0;
    ctrl_o.trial = trial_q;
    case (state_q)
      StIdle: begin
        if (start_i && cnt_sat != '0) begin
          ctrl_o.load = 1'b1;
          left_d  = cnt_sat;
          trial_d = '0;
          if (nsym == '0) begin
            valid_d = 1'b1;
            out_d   = '{symbol_index: '0, symbol_char: '0, last: 1'b1, no_match: 1'b1};
          end else begin
            state_d = StMul;
          end
        end
      end
      StMul: begin
        ctrl_o.mul_en = 1'b1;
        state_d = StCmp;
      end
      StCmp: begin
        if (stat_i.hit) begin
          ctrl_o.take = 1'b1;
          valid_d = 1'b1;
          out_d.symbol_index = trial_q;
          out_d.symbol_char  = chars_i[trial_q*CharW +: CharW];
          out_d.last         = (left_dec == '0);
          out_d.no_match     = 1'b0;
          left_d  = left_dec;
          trial_d = '0;
          state_d = (left_dec == '0) ? StIdle : StMul;
        end else if (last_trial) begin
          valid_d = 1'b1;
          out_d   = '{symbol_index: '0, symbol_char: '0, last: 1'b1, no_match: 1'b1};
          left_d  = '0;
          state_d = StIdle;
        end else begin
          ctrl_o.step = 1'b1;
          trial_d = trial_q + 3'd1;
          state_d = StMul;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      trial_q <= '0;
      left_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      trial_q <= trial_d;
      left_q  <= left_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign busy_o  = (state_q != StIdle);
  assign valid_o = valid_q;
  assign out_o   = out_q;

endmodule

FILE: src/aid_checker.sv
`include "arith_interval_decoder_defines.svh"

module aid_checker
  import aid_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     busy_i,
  input logic     valid_i,
  input aid_out_t out_i
);

  logic fields_zero;
  assign fields_zero = (out_i.symbol_index == '0) && (out_i.symbol_char == '0);

  `AID_ASSERT_IMP(a_nomatch_last, valid_i && out_i.no_match, out_i.last, "no_match without last")
  `AID_ASSERT_IMP(a_nomatch_zero, valid_i && out_i.no_match, fields_zero, "no_match fields not zero")
  `AID_ASSERT_IMP(a_more_busy, valid_i && !out_i.last, busy_i, "idle with results pending")
  `AID_ASSERT_NXT(a_gap, valid_i && !out_i.last, !valid_i && busy_i, "results too close")

endmodule

bind arith_interval_decoder aid_checker u_aid_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .busy_i (busy),
  .valid_i(valid_o),
  .out_i  (out_o)
);
